/* rtl/url_percent_decoder_defines.svh */
// Assertion macros for the URL percent decoder
`ifndef URL_PERCENT_DECODER_DEFINES_SVH
`define URL_PERCENT_DECODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define URLPD_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("url_percent_decoder: check failed");

// next-cycle implication, checked outside reset
`define URLPD_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("url_percent_decoder: check failed");

`endif

/* rtl/urlpd_pkg.sv */
// Types, constants and helpers shared by the URL percent decoder
package urlpd_pkg;

  localparam int unsigned CntW      = 12;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);
  localparam logic [CntW-1:0] MaxOutReset = 12'd63;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [3:0] HEX_TEN  = 4'd10;

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_PCT   = 2'd1,
    PEND_DIGIT = 2'd2
  } pend_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
    logic       truncated;
  } out_t;

  // one queued item: up to three decoded bytes, or a bare end marker
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            bare;
    logic            last;
    logic            trunc;
  } job_t;

  function automatic logic is_hex(logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LF) ||
           (c >= CH_UA && c <= CH_UF);
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
    end else if (c >= CH_LA && c <= CH_LF) begin
      d = c - CH_LA;
      d = d + {4'd0, HEX_TEN};
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA;
      d = d + {4'd0, HEX_TEN};
    end
    return d[3:0];
  endfunction

endpackage

/* rtl/url_percent_decoder.sv */
// Streaming form-urlencoded value decoder, top level.
// One raw byte is taken per cycle while the four-item queue between the
// front end and the output sequencer has room; the front end resolves
// '+', percent escapes and the per-value output limit in the cycle it
// takes the byte. Each byte gives zero to three results, more than one
// only where a broken escape is flushed, and the output sequencer sends
// one result per cycle while out_ready_i is high. The output limit
// (max_q) resets to 63.
`include "url_percent_decoder_defines.svh"

module url_percent_decoder import urlpd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_t             in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_t            out_data_o
);

  logic q_push, q_pop, q_not_full, q_not_empty;
  job_t q_wdata, q_rdata;

  urlpd_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .q_not_full_i (q_not_full),
    .q_push_o     (q_push),
    .q_job_o      (q_wdata)
  );

  urlpd_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (q_push),
    .wdata_i     (q_wdata),
    .not_full_o  (q_not_full),
    .pop_i       (q_pop),
    .rdata_o     (q_rdata),
    .not_empty_o (q_not_empty)
  );

  urlpd_back u_back (
    .clk_i,
    .rst_ni,
    .q_not_empty_i (q_not_empty),
    .q_job_i       (q_rdata),
    .q_pop_o       (q_pop),
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

  `URLPD_ASSERT_NOW(a_bare_is_final, out_valid_o && !out_data_o.out_valid, out_data_o.out_last)
  `URLPD_ASSERT_NOW(a_bare_zero, out_valid_o && !out_data_o.out_valid, out_data_o.out_byte == 8'd0)
  `URLPD_ASSERT_NEXT(a_queue_drains, q_not_empty && !out_valid_o, out_valid_o)

endmodule

/* rtl/urlpd_front.sv */
// Front end: takes bytes, tracks escapes and the output limit, builds queue items
module urlpd_front import urlpd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_t             in_data_i,
  input  logic            q_not_full_i,
  output logic            q_push_o,
  output job_t            q_job_o
);

  pend_e           pend_q, pend_d;
  logic [7:0]      dig_q, dig_d;
  logic [CntW-1:0] emit_q, emit_d;
  logic            drop_q, drop_d;
  logic [CntW-1:0] max_q;

  logic            accept;
  logic [7:0]      b;
  logic            last;
  logic            hex;
  logic [7:0]      plain_b;
  logic            plain_pend;
  logic [2:0][7:0] cand;
  logic [1:0]      ncand;
  logic [CntW-1:0] e;
  logic [1:0]      acc;
  logic            drop;

  assign b          = in_data_i.in_byte;
  assign last       = in_data_i.in_last;
  assign hex        = is_hex(b);
  assign plain_b    = (b == CH_PLUS) ? CH_SPACE : b;
  assign plain_pend = (b == CH_PCT) && !last;
  assign in_ready_o = q_not_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // next escape state
  always_comb begin
    pend_d = pend_q;
    dig_d  = dig_q;
    case (pend_q)
      PEND_NONE: begin
        if (plain_pend) pend_d = PEND_PCT;
      end
      PEND_PCT: begin
        if (hex && !last) begin
          pend_d = PEND_DIGIT;
          dig_d  = b;
        end else begin
          pend_d = plain_pend ? PEND_PCT : PEND_NONE;
        end
      end
      PEND_DIGIT: begin
        pend_d = (!hex && plain_pend) ? PEND_PCT : PEND_NONE;
      end
      default: pend_d = PEND_NONE;
    endcase
  end

  // candidate bytes this item produces
  always_comb begin
    cand  = '0;
    ncand = 2'd0;
    case (pend_q)
      PEND_NONE: begin
        if (!plain_pend) begin
          cand[0] = plain_b;
          ncand   = 2'd1;
        end
      end
      PEND_PCT: begin
        if (!(hex && !last)) begin
          cand[0] = CH_PCT;
          cand[1] = plain_b;
          ncand   = plain_pend ? 2'd1 : 2'd2;
        end
      end
      PEND_DIGIT: begin
        if (hex) begin
          cand[0] = {hex_val(dig_q), hex_val(b)};
          ncand   = 2'd1;
        end else begin
          cand[0] = CH_PCT;
          cand[1] = dig_q;
          cand[2] = plain_b;
          ncand   = plain_pend ? 2'd2 : 2'd3;
        end
      end
      default: ncand = 2'd0;
    endcase
  end

  // output limit over up to three bytes
  always_comb begin
    e    = emit_q;
    acc  = 2'd0;
    drop = drop_q;
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < ncand) begin
        if (e < max_q) begin
          e   = e + 12'd1;
          acc = acc + 2'd1;
        end else begin
          drop = 1'b1;
        end
      end
    end
    emit_d = e;
    drop_d = drop;
  end

  always_comb begin
    q_job_o.bytes    = cand;
    q_job_o.bare     = (acc == 2'd0);
    q_job_o.last_idx = (acc == 2'd0) ? 2'd0 : acc - 2'd1;
    q_job_o.last     = last;
    q_job_o.trunc    = drop_d;
    q_push_o         = accept && ((acc != 2'd0) || last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxOutReset;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= PEND_NONE;
      dig_q  <= 8'd0;
      emit_q <= '0;
      drop_q <= 1'b0;
    end else if (accept) begin
      if (last) begin
        pend_q <= PEND_NONE;
        dig_q  <= 8'd0;
        emit_q <= '0;
        drop_q <= 1'b0;
      end else begin
        pend_q <= pend_d;
        dig_q  <= dig_d;
        emit_q <= emit_d;
        drop_q <= drop_d;
      end
    end
  end

endmodule

/* rtl/urlpd_queue.sv */
// Short item queue between the front end and the output sequencer
module urlpd_queue import urlpd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t wdata_i,
  output logic not_full_o,
  input  logic pop_i,
  output job_t rdata_o,
  output logic not_empty_o
);

  job_t [QDepth-1:0] mem_q;
  logic [QPtrW-1:0]  wr_q, rd_q;
  logic [QCntW-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign not_full_o  = (cnt_q != QCntW'(QDepth));
  assign not_empty_o = (cnt_q != '0);
  assign do_push     = push_i && not_full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign rdata_o     = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + QPtrW'(1);
      if (do_pop)  rd_q <= rd_q + QPtrW'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QCntW'(1);
        2'b01:   cnt_q <= cnt_q - QCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* rtl/urlpd_back.sv */
// Output sequencer: sends the bytes of each queued item one per cycle while out_ready_i is high
module urlpd_back import urlpd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_not_empty_i,
  input  job_t q_job_i,
  output logic q_pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  job_t       cur_q;
  logic       cur_v_q;
  logic [1:0] idx_q;
  logic       at_end;
  logic       done;
  logic [7:0] sel;

  assign at_end      = (idx_q == cur_q.last_idx);
  assign done        = !cur_v_q || (out_ready_i && at_end);
  assign q_pop_o     = done && q_not_empty_i;
  assign out_valid_o = cur_v_q;

  always_comb begin
    case (idx_q)
      2'd0:    sel = cur_q.bytes[0];
      2'd1:    sel = cur_q.bytes[1];
      2'd2:    sel = cur_q.bytes[2];
      default: sel = 8'd0;
    endcase
    out_data_o.out_byte  = cur_q.bare ? 8'd0 : sel;
    out_data_o.out_valid = !cur_q.bare;
    out_data_o.out_last  = cur_q.last && at_end;
    out_data_o.truncated = cur_q.trunc;
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) cur_q <= q_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (done) begin
      cur_v_q <= q_not_empty_i;
      idx_q   <= 2'd0;
    end else if (out_ready_i) begin
      idx_q   <= idx_q + 2'd1;
    end
  end

endmodule
